// File: rtl/core/tlps_pkg.sv
// Package for the three-level priority scheduler with aging.
// Holds sizes, level and command codes, and register indexes used by the core, the checker and the testbench.
// No dependencies.
package tlps_pkg;

   localparam int NUM_PROCS = 64;
   localparam int NUM_Q     = 3;
   localparam int PID_W     = 6;
   localparam int LVL_W     = 2;
   localparam int CD_W      = 8;
   localparam int CNT_W     = $clog2(NUM_PROCS + 1);
   localparam int IDX_W     = (NUM_PROCS > 2) ? $clog2(NUM_PROCS) : 1;
   localparam int ROW_W     = (IDX_W > 1) ? IDX_W - 1 : 1;
   localparam int ROWS      = 2 ** ROW_W;

   localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
   localparam logic [LVL_W-1:0] LVL_MED  = 2'd1;
   localparam logic [LVL_W-1:0] LVL_HIGH = 2'd2;

   localparam logic CMD_READY   = 1'b0;
   localparam logic CMD_RESCHED = 1'b1;

   localparam logic REG_AGING_EN = 1'b0;
   localparam logic REG_QUANTUM  = 1'b1;

   localparam logic [CD_W-1:0] QUANTUM_RST = 8'd10;

endpackage

// File: rtl/core/tlps_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
// Depends on nothing; used for the scheduler's queue banks.
module tlps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/three_level_priority_scheduler_aging_top.sv
// Three-level ready-queue scheduler with aging: top level with queue banks and CSR port.
// Each response beat is registered and shows in the cycle after its request is accepted.
// Throughput: one beat per cycle unless stalled; queue logic precedes the result register.
// Each queue is two interleaved RAM banks so two pushes land in one cycle.
// Reset clears counts, heads, cur id; countdowns, quantum load 10, aging on; RAM not cleared.
// Depends on tlps_pkg and tlps_ram.
module three_level_priority_scheduler_aging_top
   import tlps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [5:0] pid, [7:6] priority_req, [8] current_runs, rest 0
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] next_pid, [6] none_ready, [7] overflow
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef struct packed {
      logic [CNT_W-1:0]            cnt;
      logic [IDX_W-1:0]            head;
      logic [PID_W-1:0]            front;
      logic [1:0]                  nwr;
      logic [1:0][IDX_W-1:0]       wpos;
      logic [1:0][PID_W-1:0]       wval;
   } qwork_type;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_PROCS);

   function automatic logic q_full(qwork_type q);
      return q.cnt >= CNT_FULL;
   endfunction

   function automatic qwork_type q_push(qwork_type q, logic [PID_W-1:0] v);
      qwork_type r;
      r = q;
      if (r.cnt == '0) begin
         r.front = v;
      end
      r.wpos[r.nwr[0]] = r.head + IDX_W'(r.cnt);
      r.wval[r.nwr[0]] = v;
      r.nwr = r.nwr + 2'd1;
      r.cnt = r.cnt + CNT_W'(1);
      return r;
   endfunction

   function automatic qwork_type q_pop(qwork_type q);
      qwork_type r;
      r = q;
      r.head = r.head + IDX_W'(1);
      r.cnt = r.cnt - CNT_W'(1);
      return r;
   endfunction

   logic                 req_fire;
   logic                 csr_wr;
   logic                 aging_ff, aging_in;
   logic [CD_W-1:0]      quantum_ff, quantum_in;
   logic [CD_W-1:0]      med_cd_ff, med_cd_in;
   logic [CD_W-1:0]      low_cd_ff, low_cd_in;
   logic [PID_W-1:0]     cur_ff, cur_in;
   logic [CNT_W-1:0]     cnt_ff [NUM_Q];
   logic [IDX_W-1:0]     head_ff [NUM_Q];
   logic [IDX_W-1:0]     head_in [NUM_Q];
   logic                 hit_ff [NUM_Q];
   logic                 hit_in [NUM_Q];
   logic [PID_W-1:0]     byp_ff [NUM_Q];
   logic [PID_W-1:0]     byp_in [NUM_Q];
   logic [PID_W-1:0]     head_val [NUM_Q];
   logic [PID_W-1:0]     rd_data [NUM_Q][2];
   logic                 wr_en [NUM_Q][2];
   logic [ROW_W-1:0]     wr_addr [NUM_Q][2];
   logic [PID_W-1:0]     wr_data [NUM_Q][2];
   qwork_type            q [NUM_Q];
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_data_ff, rsp_data_in;
   logic [LVL_W-1:0]     lvl;
   logic                 none_ready;
   logic                 overflow;
   logic [PID_W-1:0]     mv;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // CSR port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_QUANTUM) ? {24'd0, quantum_ff} : {31'd0, aging_ff};

   always_comb begin
      aging_in   = aging_ff;
      quantum_in = quantum_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_AGING_EN: aging_in   = csr_pwdata[0];
            REG_QUANTUM:  quantum_in = csr_pwdata[CD_W-1:0];
            default:      aging_in   = aging_ff;
         endcase
      end
   end

   // queue head values: RAM read of last head, with same-edge write bypass
   always_comb begin
      for (int i = 0; i < NUM_Q; i++) begin
         head_val[i] = hit_ff[i] ? byp_ff[i] : rd_data[i][head_ff[i][0]];
      end
   end

   // scheduling step
   always_comb begin
      for (int i = 0; i < NUM_Q; i++) begin
         q[i].cnt   = cnt_ff[i];
         q[i].head  = head_ff[i];
         q[i].front = head_val[i];
         q[i].nwr   = 2'd0;
         q[i].wpos  = '0;
         q[i].wval  = '0;
      end
      med_cd_in  = med_cd_ff;
      low_cd_in  = low_cd_ff;
      cur_in     = cur_ff;
      none_ready = 1'b0;
      overflow   = 1'b0;
      mv         = '0;
      lvl        = (req_tdata[7:6] == LVL_LOW) ? LVL_LOW :
                   (req_tdata[7:6] == LVL_MED) ? LVL_MED : LVL_HIGH;

      if (req_tuser == CMD_READY) begin
         if (q_full(q[lvl])) begin
            overflow = 1'b1;
         end else begin
            q[lvl] = q_push(q[lvl], req_tdata[5:0]);
         end
      end else begin
         if (aging_ff) begin
            med_cd_in = med_cd_ff - CD_W'(1);
            if (med_cd_in == '0) begin
               med_cd_in = quantum_ff;
               low_cd_in = low_cd_ff - CD_W'(1);
               if (q[LVL_MED].cnt != '0 && !q_full(q[LVL_HIGH])) begin
                  mv          = q[LVL_MED].front;
                  q[LVL_MED]  = q_pop(q[LVL_MED]);
                  q[LVL_HIGH] = q_push(q[LVL_HIGH], mv);
               end
            end
            if (low_cd_in == '0) begin
               low_cd_in = quantum_ff;
               if (q[LVL_LOW].cnt != '0 && !q_full(q[LVL_MED])) begin
                  mv         = q[LVL_LOW].front;
                  q[LVL_LOW] = q_pop(q[LVL_LOW]);
                  q[LVL_MED] = q_push(q[LVL_MED], mv);
               end
            end
         end
         if (req_tdata[8]) begin
            if (q_full(q[lvl])) begin
               overflow = 1'b1;
            end else begin
               q[lvl] = q_push(q[lvl], cur_ff);
            end
         end
         if (q[LVL_HIGH].cnt != '0) begin
            cur_in      = q[LVL_HIGH].front;
            q[LVL_HIGH] = q_pop(q[LVL_HIGH]);
         end else if (q[LVL_MED].cnt != '0) begin
            cur_in     = q[LVL_MED].front;
            q[LVL_MED] = q_pop(q[LVL_MED]);
         end else if (q[LVL_LOW].cnt != '0) begin
            cur_in     = q[LVL_LOW].front;
            q[LVL_LOW] = q_pop(q[LVL_LOW]);
         end else begin
            none_ready = 1'b1;
         end
      end
      rsp_data_in = {overflow, none_ready, cur_in};
   end

   // bank writes, read addresses and bypass
   always_comb begin
      for (int i = 0; i < NUM_Q; i++) begin
         head_in[i] = req_fire ? q[i].head : head_ff[i];
         hit_in[i]  = 1'b0;
         byp_in[i]  = q[i].wval[0];
         for (int b = 0; b < 2; b++) begin
            wr_en[i][b]   = 1'b0;
            wr_addr[i][b] = '0;
            wr_data[i][b] = '0;
         end
         for (int k = 0; k < 2; k++) begin
            if (req_fire && q[i].nwr > 2'(k)) begin
               wr_en[i][q[i].wpos[k][0]]   = 1'b1;
               wr_addr[i][q[i].wpos[k][0]] = ROW_W'(q[i].wpos[k] >> 1);
               wr_data[i][q[i].wpos[k][0]] = q[i].wval[k];
               if (q[i].wpos[k] == q[i].head) begin
                  hit_in[i] = 1'b1;
                  byp_in[i] = q[i].wval[k];
               end
            end
         end
      end
   end

   for (genvar gi = 0; gi < NUM_Q; gi++) begin : g_queue
      for (genvar gb = 0; gb < 2; gb++) begin : g_bank
         tlps_ram #(
            .WIDTH (PID_W),
            .DEPTH (ROWS)
         ) u_bank (
            .clock   (clock),
            .wr_en   (wr_en[gi][gb]),
            .wr_addr (wr_addr[gi][gb]),
            .wr_data (wr_data[gi][gb]),
            .rd_addr (ROW_W'(head_in[gi] >> 1)),
            .rd_data (rd_data[gi][gb])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aging_ff     <= 1'b1;
         quantum_ff   <= QUANTUM_RST;
         med_cd_ff    <= QUANTUM_RST;
         low_cd_ff    <= QUANTUM_RST;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_Q; i++) begin
            cnt_ff[i]  <= '0;
            head_ff[i] <= '0;
            hit_ff[i]  <= 1'b0;
         end
      end else begin
         aging_ff   <= aging_in;
         quantum_ff <= quantum_in;
         for (int i = 0; i < NUM_Q; i++) begin
            head_ff[i] <= head_in[i];
            hit_ff[i]  <= hit_in[i];
         end
         if (req_fire) begin
            med_cd_ff <= med_cd_in;
            low_cd_ff <= low_cd_in;
            cur_ff    <= cur_in;
            for (int i = 0; i < NUM_Q; i++) begin
               cnt_ff[i] <= q[i].cnt;
            end
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_Q; i++) begin
         byp_ff[i] <= byp_in[i];
      end
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= CNT_FULL && cnt_ff[1] <= CNT_FULL && cnt_ff[2] <= CNT_FULL)
      else $error("queue count above capacity");

   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      ($past(req_fire) && !$past(reset) && rsp_tdata[6]) |->
      (cnt_ff[0] == '0 && cnt_ff[1] == '0 && cnt_ff[2] == '0))
      else $error("none_ready with a nonempty queue");

   a_ready_keeps_cur: assert property (@(posedge clock) disable iff (reset)
      ($past(req_fire) && !$past(reset) && $past(req_tuser) == CMD_READY) |->
      cur_ff == $past(cur_ff))
      else $error("ready command changed the current process");

endmodule

// File: tb/sv/tlps_sched_checker.sv
// Checker for the three-level priority scheduler: watches the request, response and CSR ports,
// predicts each response from its own copy of the ready queues, and compares beat by beat.
// Depends on tlps_pkg.
module tlps_sched_checker
   import tlps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [5:0] pid, [7:6] priority_req, [8] current_runs, rest 0
   input  logic        req_tuser,   // [0] cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [5:0] next_pid, [6] none_ready, [7] overflow
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          errors,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic             overflow;
      logic             none_ready;
      logic [PID_W-1:0] next_pid;
   } sched_pick_type;

   logic [PID_W-1:0] ready_store [NUM_Q][NUM_PROCS];
   logic [IDX_W-1:0] q_head      [NUM_Q];
   logic [CNT_W-1:0] q_count     [NUM_Q];
   logic [PID_W-1:0] running_pid;
   logic [CD_W-1:0]  med_timer;
   logic [CD_W-1:0]  low_timer;
   logic             aging_on;
   logic [CD_W-1:0]  reload;
   sched_pick_type   expected_picks [$];

   function automatic bit enqueue(int lvl, logic [PID_W-1:0] id);
      int slot;
      if (q_count[lvl] >= NUM_PROCS) return 1'b0;
      slot = (int'(q_head[lvl]) + int'(q_count[lvl])) % NUM_PROCS;
      ready_store[lvl][slot] = id;
      q_count[lvl] = q_count[lvl] + 1'b1;
      return 1'b1;
   endfunction

   function automatic logic [PID_W-1:0] dequeue(int lvl);
      logic [PID_W-1:0] id;
      id = ready_store[lvl][q_head[lvl]];
      q_head[lvl] = IDX_W'((int'(q_head[lvl]) + 1) % NUM_PROCS);
      q_count[lvl] = q_count[lvl] - 1'b1;
      return id;
   endfunction

   function automatic void promote(int from, int to);
      if (q_count[from] != 0 && q_count[to] < NUM_PROCS) void'(enqueue(to, dequeue(from)));
   endfunction

   function automatic void age_queues();
      med_timer = med_timer - 1'b1;
      if (med_timer == '0) begin
         med_timer = reload;
         low_timer = low_timer - 1'b1;
         promote(int'(LVL_MED), int'(LVL_HIGH));
      end
      if (low_timer == '0) begin
         low_timer = reload;
         promote(int'(LVL_LOW), int'(LVL_MED));
      end
   endfunction

   function automatic sched_pick_type predict_schedule(logic cmd, logic [PID_W-1:0] pid,
                                                       logic [LVL_W-1:0] prio, logic runs);
      sched_pick_type pick;
      int             lvl;
      pick = '0;
      lvl = (prio > LVL_HIGH) ? int'(LVL_HIGH) : int'(prio);
      if (cmd == CMD_READY) begin
         pick.overflow = !enqueue(lvl, pid);
      end else begin
         if (aging_on) age_queues();
         if (runs && !enqueue(lvl, running_pid)) pick.overflow = 1'b1;
         if (q_count[LVL_HIGH] != 0) running_pid = dequeue(int'(LVL_HIGH));
         else if (q_count[LVL_MED] != 0) running_pid = dequeue(int'(LVL_MED));
         else if (q_count[LVL_LOW] != 0) running_pid = dequeue(int'(LVL_LOW));
         else pick.none_ready = 1'b1;
      end
      pick.next_pid = running_pid;
      return pick;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (errors < 100) $display("%0t ns mismatch %s: got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      sched_pick_type got;
      sched_pick_type want;
      if (reset) begin
         for (int i = 0; i < NUM_Q; i++) begin
            q_head[i] = '0;
            q_count[i] = '0;
         end
         running_pid = '0;
         med_timer = QUANTUM_RST;
         low_timer = QUANTUM_RST;
         aging_on = 1'b1;
         reload = QUANTUM_RST;
         expected_picks.delete();
         errors = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_AGING_EN) aging_on = csr_pwdata[0];
            else if (csr_paddr[2] == REG_QUANTUM) reload = csr_pwdata[CD_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_picks.size() == 0) begin
               report_mismatch("response beat with nothing expected", int'(got), -1);
            end else begin
               want = expected_picks.pop_front();
               if (got.next_pid !== want.next_pid)
                  report_mismatch("next_pid", int'(got.next_pid), int'(want.next_pid));
               if (got.none_ready !== want.none_ready)
                  report_mismatch("none_ready", int'(got.none_ready), int'(want.none_ready));
               if (got.overflow !== want.overflow)
                  report_mismatch("overflow", int'(got.overflow), int'(want.overflow));
            end
         end
         if (req_tvalid && req_tready)
            expected_picks.push_back(predict_schedule(req_tuser, req_tdata[5:0], req_tdata[7:6],
                                                      req_tdata[8]));
      end
      pending = expected_picks.size();
   end

endmodule

// File: tb/sv/tb_three_level_priority_scheduler_aging_top.sv
// Testbench top for the three-level priority scheduler: drives request beats, response
// back-pressure and CSR writes, and gives the verdict from the checker's failure count.
// Depends on tlps_pkg, tlps_sched_checker and the scheduler RTL.
module tb_three_level_priority_scheduler_aging_top
   import tlps_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [5:0] pid, [7:6] priority_req, [8] current_runs, rest 0
   logic        req_tuser;   // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [5:0] next_pid, [6] none_ready, [7] overflow
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          errors;
   int          pending;
   bit          calm;
   bit          stall_long;

   three_level_priority_scheduler_aging_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tlps_sched_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .errors      (errors),
      .pending     (pending)
   );

   always #10 clock = ~clock;

   task automatic issue(logic cmd, logic [PID_W-1:0] pid, logic [LVL_W-1:0] prio, logic runs);
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = cmd;
      req_tdata = {7'd0, runs, prio, pid};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic run_phase(int n_items);
      int               sent;
      int               mode;
      int               len;
      logic [LVL_W-1:0] lvl;
      sent = 0;
      while (sent < n_items) begin
         mode = $urandom_range(0, 9);
         len = (mode < 3) ? $urandom_range(8, 80) : $urandom_range(4, 40);
         if (len > n_items - sent) len = n_items - sent;
         lvl = LVL_W'($urandom_range(0, 3));
         repeat (len) begin
            if (mode < 3)
               issue(CMD_READY, PID_W'($urandom_range(0, 63)), lvl, 1'($urandom_range(0, 1)));
            else if (mode < 6)
               issue(CMD_RESCHED, PID_W'($urandom_range(0, 63)), LVL_W'($urandom_range(0, 3)),
                     $urandom_range(0, 3) != 0);
            else
               issue(1'($urandom_range(0, 1)), PID_W'($urandom_range(0, 63)),
                     LVL_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            sent++;
         end
      end
      drain();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_READY;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      calm = 1'b0;
      stall_long = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      issue(CMD_RESCHED, 6'd0,  LVL_LOW,  1'b0);
      issue(CMD_RESCHED, 6'd0,  LVL_HIGH, 1'b1);
      issue(CMD_READY,   6'd63, LVL_LOW,  1'b0);
      issue(CMD_READY,   6'd0,  LVL_MED,  1'b1);
      issue(CMD_READY,   6'd42, LVL_HIGH, 1'b0);
      issue(CMD_READY,   6'd21, 2'd3,     1'b1);
      issue(CMD_RESCHED, 6'd63, LVL_LOW,  1'b0);
      issue(CMD_RESCHED, 6'd0,  2'd3,     1'b1);
      issue(CMD_RESCHED, 6'd63, LVL_LOW,  1'b1);
      issue(CMD_RESCHED, 6'd0,  LVL_MED,  1'b0);
      issue(CMD_RESCHED, 6'd63, LVL_HIGH, 1'b0);
      issue(CMD_RESCHED, 6'd0,  LVL_LOW,  1'b0);
      issue(CMD_RESCHED, 6'd63, 2'd3,     1'b0);
      issue(CMD_READY,   6'd63, LVL_MED,  1'b0);
      issue(CMD_RESCHED, 6'd0,  LVL_MED,  1'b1);
      issue(CMD_RESCHED, 6'd0,  LVL_MED,  1'b0);
      drain();

      run_phase(150);
      csr_write(REG_QUANTUM, 32'd1);
      run_phase(200);
      csr_write(REG_AGING_EN, 32'd0);
      run_phase(150);
      csr_write(REG_AGING_EN, 32'd1);
      csr_write(REG_QUANTUM, 32'd255);
      run_phase(150);
      csr_write(REG_QUANTUM, 32'd0);
      run_phase(200);
      csr_write(REG_QUANTUM, 32'd3);
      stall_long = 1'b1;
      run_phase(200);
      csr_write(REG_QUANTUM, 32'd2);
      calm = 1'b1;
      run_phase(200);

      repeat (5) @(negedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      int n;
      bit stall_done;
      rsp_tready = 1'b0;
      stall_done = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_long && !stall_done) begin
            rsp_tready = 1'b0;
            repeat (80) @(negedge clock);
            stall_done = 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 8);
            rsp_tready = 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            n = $urandom_range(1, 16);
            rsp_tready = 1'b1;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   initial begin
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/tlps_pkg.sv
rtl/core/tlps_ram.sv
rtl/core/three_level_priority_scheduler_aging_top.sv
tb/sv/tlps_sched_checker.sv
tb/sv/tb_three_level_priority_scheduler_aging_top.sv
